>>> rtl/varint_length_prefixed_deframer_macros.svh
// Assertion macros for the varint length-prefixed deframer.
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define VLPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define VLPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VLPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VLPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/vlpd_pkg.sv
// Types and constants shared by the deframer modules.
`default_nettype none
package vlpd_pkg;

    localparam logic [7:0] CONT_BIT = 8'h80;
    localparam logic [3:0] HDR_MAX  = 4'd10;
    localparam logic [7:0] NEWLINE  = 8'h0A;
    localparam int unsigned CFG_W   = 9;
    // three 7-bit groups at most before a length counts as oversize, plus carry
    localparam int unsigned SUM_W   = 22;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_HDR_LONG = 2'd2,
        ST_NO_NL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       keep_byte;
        logic       end_of_message;
        status_t    status;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/varint_length_prefixed_deframer.sv
// Top level of the LEB128 length-prefixed message deframer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | sink      | in_valid / in_ready    | in_byte
//  out     | source    | out_valid / out_ready  | payload_byte, keep_byte,
//          |           |                        | end_of_message, status
//  cfg     | sink      | cfg_valid / cfg_ready  | max_length (capacity)
//
// One byte per cycle sustained while the output is not stalled. A byte waits
// in the input register; the core step (header group add and compare, or
// payload count) runs between that register and the result register, which
// holds the result until it transfers. Header bytes that raise no error give
// no result.
// Reset is asynchronous and active low; capacity resets to 256, framing to
// header phase. A stalled output holds the result register; the input
// register then fills and in_ready drops until out_ready returns.
// cfg_ready is always high.
`default_nettype none
`include "varint_length_prefixed_deframer_macros.svh"
module varint_length_prefixed_deframer
    import vlpd_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            payload_byte,
    output logic                  keep_byte,
    output logic                  end_of_message,
    output logic [1:0]            status,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] max_length
);

    logic [CFG_W-1:0] max_length_reg;
    logic [CFG_W-1:0] max_length_next;
    logic             hold_valid;
    logic [7:0]       hold_byte;
    logic             advance;
    logic             res_valid;
    result_t          res;
    result_t          out_res;

    // capacity register; writes must come only while the block is idle (not enforced here)
    assign cfg_ready       = 1'b1;
    assign max_length_next = (cfg_valid && cfg_ready) ? max_length : max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= CFG_W'(256);
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    // the held byte steps the core when the result slot is free or draining
    assign advance = hold_valid && (!out_valid || out_ready);

    vlpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    vlpd_core #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .byte_in    (hold_byte),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    vlpd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_valid (res_valid),
        .load_res   (res),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_res    (out_res)
    );

    assign payload_byte   = out_res.payload_byte;
    assign keep_byte      = out_res.keep_byte;
    assign end_of_message = out_res.end_of_message;
    assign status         = out_res.status;

    // error results carry a zero byte, no keep, and close the message
    `VLPD_ASSERT_IMP(a_err_shape, clk, rst_n, out_valid && (out_res.status != ST_OK),
                     end_of_message && !keep_byte && (payload_byte == 8'd0))
    // a mid-message byte is always a kept, good byte
    `VLPD_ASSERT_IMP(a_mid_kept, clk, rst_n, out_valid && !end_of_message,
                     keep_byte && (out_res.status == ST_OK))
    // an empty result slot never backs up the input
    `VLPD_ASSERT_IMP(a_in_free, clk, rst_n, !out_valid, in_ready)
    // a result produced by a core step shows on the next cycle
    `VLPD_ASSERT_NXT(a_res_shown, clk, rst_n, advance && res_valid, out_valid)

endmodule
`default_nettype wire

>>> rtl/vlpd_in_stage.sv
// Input register stage: holds one byte until the core consumes it.
`default_nettype none
module vlpd_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       advance,
    output logic            hold_valid,
    output logic [7:0]      hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // free slot, or the held byte leaves this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule
`default_nettype wire

>>> rtl/vlpd_core.sv
// Header decode and payload count: framing state and one-byte step logic.
`default_nettype none
module vlpd_core
    import vlpd_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       byte_in,
    input  wire logic [CFG_W-1:0] max_length,
    output logic                  res_valid,
    output result_t               res
);

    localparam int unsigned LEN_W = $clog2(MAX_CAPACITY + 1);
    localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic             in_payload_reg, in_payload_next;
    logic [3:0]       header_count_reg, header_count_next;
    logic [LEN_W-1:0] length_accum_reg, length_accum_next;
    logic             length_oversize_reg, length_oversize_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;

    logic [CMP_W-1:0] cap_raw;
    logic [CMP_W-1:0] cap;
    logic [6:0]       data;
    logic [3:0]       cnt;
    logic [SUM_W-1:0] group;
    logic [SUM_W-1:0] sum;

    assign cap_raw = CMP_W'(max_length);
    assign cap     = (cap_raw > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY) : cap_raw;
    assign data    = byte_in[6:0];
    assign cnt     = header_count_reg + 4'd1;

    always_comb
    begin
        unique case (header_count_reg[1:0])
            2'd0:    group = SUM_W'(data);
            2'd1:    group = SUM_W'({data, 7'd0});
            default: group = SUM_W'({data, 14'd0});
        endcase
    end

    assign sum = SUM_W'(length_accum_reg) + group;

    always_comb
    begin
        in_payload_next      = in_payload_reg;
        header_count_next    = header_count_reg;
        length_accum_next    = length_accum_reg;
        length_oversize_next = length_oversize_reg;
        bytes_left_next      = bytes_left_reg;
        res_valid            = 1'b0;
        res.payload_byte     = byte_in;
        res.keep_byte        = 1'b1;
        res.end_of_message   = 1'b0;
        res.status           = ST_OK;

        if (in_payload_reg)
        begin
            res_valid = 1'b1;
            if (bytes_left_reg > LEN_W'(1))
            begin
                bytes_left_next = bytes_left_reg - LEN_W'(1);
            end
            else
            begin
                in_payload_next      = 1'b0;
                header_count_next    = 4'd0;
                length_accum_next    = '0;
                length_oversize_next = 1'b0;
                bytes_left_next      = '0;
                res.end_of_message   = 1'b1;
                priority if (byte_in == NEWLINE)
                begin
                    res.keep_byte = 1'b0;
                end
                else if (CMP_W'(length_accum_reg) < cap)
                begin
                    res.keep_byte = 1'b1;
                end
                else
                begin
                    res.payload_byte = 8'd0;
                    res.keep_byte    = 1'b0;
                    res.status       = ST_NO_NL;
                end
            end
        end
        else
        begin
            // accumulate a 7-bit group; wide values latch oversize, never wrap
            if (!length_oversize_reg && (data != 7'd0))
            begin
                if (header_count_reg >= 4'd3)
                begin
                    length_oversize_next = 1'b1;
                end
                else if (sum > SUM_W'(MAX_CAPACITY))
                begin
                    length_oversize_next = 1'b1;
                end
                else
                begin
                    length_accum_next = sum[LEN_W-1:0];
                end
            end
            header_count_next = cnt;

            if ((byte_in & CONT_BIT) != 8'd0)
            begin
                if (cnt >= HDR_MAX)
                begin
                    header_count_next    = 4'd0;
                    length_accum_next    = '0;
                    length_oversize_next = 1'b0;
                    res_valid            = 1'b1;
                    res.payload_byte     = 8'd0;
                    res.keep_byte        = 1'b0;
                    res.end_of_message   = 1'b1;
                    res.status           = ST_HDR_LONG;
                end
            end
            else if (length_oversize_next || (length_accum_next == '0) ||
                     (CMP_W'(length_accum_next) > cap))
            begin
                header_count_next    = 4'd0;
                length_accum_next    = '0;
                length_oversize_next = 1'b0;
                res_valid            = 1'b1;
                res.payload_byte     = 8'd0;
                res.keep_byte        = 1'b0;
                res.end_of_message   = 1'b1;
                res.status           = ST_BAD_LEN;
            end
            else
            begin
                in_payload_next   = 1'b1;
                header_count_next = 4'd0;
                bytes_left_next   = length_accum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg      <= 1'b0;
            header_count_reg    <= 4'd0;
            length_accum_reg    <= '0;
            length_oversize_reg <= 1'b0;
            bytes_left_reg      <= '0;
        end
        else if (advance)
        begin
            in_payload_reg      <= in_payload_next;
            header_count_reg    <= header_count_next;
            length_accum_reg    <= length_accum_next;
            length_oversize_reg <= length_oversize_next;
            bytes_left_reg      <= bytes_left_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vlpd_out_reg.sv
// Result register: holds one result until the consumer takes it.
`default_nettype none
module vlpd_out_reg
    import vlpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire logic    load_valid,
    input  wire result_t load_res,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
        begin
            valid_next = load_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the varint length-prefixed message deframer.
`timescale 1ns / 1ps
module tb_top;
    import vlpd_pkg::*;

    // Capacity ceiling the block is built with; the capacity the core uses is clamped to it.
    localparam int unsigned CAP_LIMIT   = 256;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 300;
    // Settle margin after the results drain, such as before a cfg write.
    localparam int unsigned SETTLE      = 6;
    localparam int unsigned PHASE_BYTES = 100;

    // Mirrors the deframer state, predicts every result and checks the
    // results coming out against the oldest prediction.
    class deframe_scoreboard;
        result_t     pending_results[$];
        int unsigned mismatches;
        logic [8:0]  max_len;
        logic        in_payload;
        logic [3:0]  header_count;
        logic [8:0]  length_accum;
        logic        length_oversize;
        logic [8:0]  bytes_left;

        function new();
            mismatches = 0;
            max_len    = 9'd256;
            to_header_phase();
        endfunction

        function void to_header_phase();
            in_payload      = 1'b0;
            header_count    = 4'd0;
            length_accum    = 9'd0;
            length_oversize = 1'b0;
            bytes_left      = 9'd0;
        endfunction

        function void set_capacity(logic [8:0] value);
            max_len = value;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void queue_result(logic [7:0] pb, logic keep, logic eom, status_t st);
            result_t r;
            r.payload_byte   = pb;
            r.keep_byte      = keep;
            r.end_of_message = eom;
            r.status         = st;
            pending_results.push_back(r);
        endfunction

        // One accepted stream byte: advance the framing state, queue any result.
        function void note_accepted_byte(logic [7:0] b);
            int unsigned cap;
            int unsigned cnt;
            int unsigned sum;
            logic [6:0]  grp;
            logic [8:0]  msg_len;
            cap = (max_len > CAP_LIMIT) ? CAP_LIMIT : max_len;
            if (in_payload)
            begin
                if (bytes_left > 1)
                begin
                    bytes_left--;
                    queue_result(b, 1'b1, 1'b0, ST_OK);
                end
                else
                begin
                    msg_len = length_accum;
                    to_header_phase();
                    if (b == NEWLINE)
                        queue_result(b, 1'b0, 1'b1, ST_OK);
                    else if (msg_len < cap)
                        queue_result(b, 1'b1, 1'b1, ST_OK);
                    else
                        queue_result(8'h00, 1'b0, 1'b1, ST_NO_NL);
                end
            end
            else
            begin
                grp = b[6:0];
                cnt = header_count;
                // wide lengths latch the oversize flag instead of wrapping
                if (!length_oversize && grp != 7'd0)
                begin
                    if (cnt >= 3)
                    begin
                        length_oversize = 1'b1;
                    end
                    else
                    begin
                        sum = length_accum + (int'(grp) << (7 * cnt));
                        if (sum > CAP_LIMIT)
                            length_oversize = 1'b1;
                        else
                            length_accum = 9'(sum);
                    end
                end
                cnt++;
                header_count = 4'(cnt);
                if ((b & CONT_BIT) != 8'h00)
                begin
                    if (cnt >= HDR_MAX)
                    begin
                        to_header_phase();
                        queue_result(8'h00, 1'b0, 1'b1, ST_HDR_LONG);
                    end
                end
                else if (length_oversize || length_accum == 9'd0 || length_accum > cap)
                begin
                    to_header_phase();
                    queue_result(8'h00, 1'b0, 1'b1, ST_BAD_LEN);
                end
                else
                begin
                    in_payload   = 1'b1;
                    header_count = 4'd0;
                    bytes_left   = length_accum;
                end
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got %02h/%0d/%0d/%0d",
                         $time, got.payload_byte, got.keep_byte, got.end_of_message,
                         got.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.payload_byte !== want.payload_byte)
                begin
                    mismatches++;
                    $display("%0t: payload_byte mismatch: expected %02h, got %02h",
                             $time, want.payload_byte, got.payload_byte);
                end
                if (got.keep_byte !== want.keep_byte)
                begin
                    mismatches++;
                    $display("%0t: keep_byte mismatch: expected %0d, got %0d",
                             $time, want.keep_byte, got.keep_byte);
                end
                if (got.end_of_message !== want.end_of_message)
                begin
                    mismatches++;
                    $display("%0t: end_of_message mismatch: expected %0d, got %0d",
                             $time, want.end_of_message, got.end_of_message);
                end
                if (got.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got.status);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic [7:0]       in_byte    = 8'h00;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    logic [7:0]       payload_byte;
    logic             keep_byte;
    logic             end_of_message;
    logic [1:0]       status;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_length = 9'd256;

    always #10 clk = ~clk;

    varint_length_prefixed_deframer #(
        .MAX_CAPACITY   (CAP_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .keep_byte      (keep_byte),
        .end_of_message (end_of_message),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_length     (cfg_length)
    );

    deframe_scoreboard sb = new();

    logic [7:0]  byte_plan[$];      // bytes queued for the current phase
    int unsigned burst_left    = 0; // sender transfers left in this burst
    bit          hold_request  = 1'b0;
    bit          holding       = 1'b0;
    int unsigned cycle_count   = 0;

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    // LEB128 header; groups above the minimum pad with redundant zero groups.
    function automatic void plan_header(longint unsigned len, int unsigned groups);
        int unsigned needed;
        int unsigned total;
        logic [7:0]  grp;
        needed = 1;
        while (needed < 10 && (len >> (7 * needed)) != 0)
            needed++;
        total = (groups > needed) ? groups : needed;
        for (int unsigned i = 0; i < total; i++)
        begin
            grp = {1'b0, 7'(len >> (7 * i))};
            if (i + 1 < total)
                grp = grp | CONT_BIT;
            byte_plan.push_back(grp);
        end
    endfunction

    // Mostly well-formed messages with random content; lengths lean small but
    // hit the capacity edges, zero and widths far beyond the counter.
    function automatic void plan_message(int unsigned cap);
        longint unsigned len;
        int unsigned     groups;
        int unsigned     top;
        int unsigned     pick;
        top  = (cap == 0) ? 3 : ((cap > 12) ? 12 : cap);
        pick = $urandom_range(0, 19);
        if (pick < 12)
            len = $urandom_range(1, top);
        else if (pick < 14)
            len = cap;
        else if (pick == 14)
            len = cap + 1;
        else if (pick < 17)
            len = $urandom_range(1, (cap == 0) ? 1 : cap);
        else if (pick == 17)
            len = 0;
        else if (pick == 18)
            len = $urandom_range(257, 20000);
        else
            len = {$urandom(), $urandom()};
        // now and then a padded header, up to one group past the limit
        groups = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        plan_header(len, groups);
        if (len >= 1 && len <= cap && groups <= 10)
        begin
            for (longint unsigned k = 1; k < len; k++)
                byte_plan.push_back(8'($urandom()));
            if ($urandom_range(0, 3) != 0)
                byte_plan.push_back(NEWLINE);
            else
                byte_plan.push_back(8'($urandom()));
        end
    endfunction

    function automatic void plan_item(int unsigned cap);
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            plan_message(cap);
        end
        else if (pick == 7)
        begin
            // line noise
            n = $urandom_range(1, 6);
            repeat (n) byte_plan.push_back(8'($urandom()));
        end
        else if (pick == 8)
        begin
            // broken header: random groups, continuation on all but maybe the last
            n = $urandom_range(1, 11);
            for (int unsigned i = 0; i < n; i++)
            begin
                if (i + 1 < n)
                    byte_plan.push_back(8'($urandom()) | CONT_BIT);
                else
                    byte_plan.push_back(8'($urandom()));
            end
        end
        else
        begin
            // truncated message: the next header lands in the payload
            n = $urandom_range(2, 12);
            plan_header(n, 0);
            repeat ($urandom_range(0, n - 1)) byte_plan.push_back(8'($urandom()));
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One byte transfer. Sender runs in bursts with random gaps between them;
    // no gaps while the receiver is held off so the block backs up.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (holding)
                gap = 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_accepted_byte(b);
    endtask

    // Stop sending and wait until every predicted result is out, then let
    // trailing header bytes (which give no result) clear the pipe.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        cfg_valid  <= 1'b1;
        cfg_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_capacity(value);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes mode every so often; a hold request
    // parks out_ready low for a long stretch.
    // ------------------------------------------------------------------
    initial
    begin
        result_t     got;
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.payload_byte   = payload_byte;
                got.keep_byte      = keep_byte;
                got.end_of_message = end_of_message;
                got.status         = status_t'(status);
                sb.check_result(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holding      = 1'b1;
            end
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    holding = 1'b0;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 100);
                end
                mode_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] caps[9];
        logic [7:0]       directed[$];
        caps = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd255, 9'd257, 9'd17, 9'd256, 9'd256};
        caps[7] = 9'($urandom_range(1, 256));

        // Directed bytes at the reset capacity (256):
        //  shortest message ending in a newline, a kept final byte with
        //  extreme payload values, zero length, a length past the ceiling,
        //  a length wide enough to trip the group counter, ten
        //  continuation bytes, and a padded header for length one.
        directed = '{8'h01, 8'h0A,
                     8'h03, 8'hFF, 8'h00, 8'h7F,
                     8'h00,
                     8'h82, 8'h02,
                     8'h80, 8'h80, 8'h80, 8'h01,
                     8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'h81, 8'h00, 8'h0A};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        // Random phases, each at its own capacity; out-of-range settings
        // (0 and above the ceiling) are part of the list.
        foreach (caps[p])
        begin
            drain_and_settle();
            write_capacity(caps[p]);
            byte_plan.delete();
            while (byte_plan.size() < PHASE_BYTES)
                plan_item((caps[p] > CAP_LIMIT) ? CAP_LIMIT : caps[p]);
            foreach (byte_plan[i])
            begin
                if (p == 2 && i == byte_plan.size() / 3)
                    hold_request = 1'b1;
                if (p == 4 && i == byte_plan.size() / 2)
                    drain_and_settle();
                send_byte(byte_plan[i]);
            end
        end

        drain_and_settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
